// File: src/crsf_pkg.sv
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared types, register map and the CRC-8 (poly 0xD5) byte step.
// ----------------------------------------------------------------------------
package crsf_pkg;

  // register map: index taken from paddr[3:2]
  localparam logic [1:0] REG_SYNC = 2'd0;
  localparam logic [1:0] REG_MIN  = 2'd1;
  localparam logic [1:0] REG_MAX  = 2'd2;

  localparam logic [7:0] SYNC_RESET = 8'hC8;
  localparam logic [5:0] MIN_RESET  = 6'd2;
  localparam logic [5:0] MAX_RESET  = 6'd62;
  localparam logic [7:0] CRC_POLY   = 8'hD5;
  localparam logic [7:0] LEN_FLOOR  = 8'd2;

  // control to the CRC accumulator
  typedef struct packed {
    logic clear;
    logic step;
  } crc_ctrl_t;

  // one byte through CRC-8, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: src/crsf_store.sv
// ----------------------------------------------------------------------------
// crsf_store
// Frame buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module crsf_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write one byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/crsf_crc8.sv
// ----------------------------------------------------------------------------
// crsf_crc8
// CRC-8 accumulator: clears to zero, folds in one byte per step.
// ----------------------------------------------------------------------------
module crsf_crc8
  import crsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  crc_ctrl_t  ctrl,
  input  logic [7:0] data,
  output logic [7:0] crc
);

  // clear or advance the running CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= '0;
    end else if (ctrl.clear) begin
      crc <= '0;
    end else if (ctrl.step) begin
      crc <= crc8_byte(crc, data);
    end
  end

endmodule

// File: src/crsf_frame_parser_crc8_core.sv
// ----------------------------------------------------------------------------
// crsf_frame_parser_crc8_core
// Byte-wise frame parser: sync hunt, length check, frame buffering, CRC-8
// check over type and payload, and resync from the buffer after a bad CRC.
//
//   channel | signals                               | dir | word
//   --------+---------------------------------------+-----+----------------------
//   in      | in_valid, in_ready, rx_byte           | in  | one received byte
//   out     | out_valid, out_ready, frame_ok,       | out | one result per byte
//           | frame_length, frame_type              |     |
//   cfg     | psel, penable, pwrite, paddr, pwdata, | in  | sync_value, min/max
//           | prdata, pready                        |     | length registers
//
// Flow: a byte that does not end a frame is accepted, then its result is handed
// to the output register. A byte that ends a frame adds CRC streaming through
// the buffer read port, and on a bad CRC a scan of the buffered positions
// plus a copy of the tail to the front, all on the single buffer read port.
// Reset: synchronous; clears control state only, the buffer is not cleared.
// Stalls: in_ready is low from accept until the result enters the output
// register; a held result stalls the next byte's result, not its acceptance.
// ----------------------------------------------------------------------------
module crsf_frame_parser_crc8_core
  import crsf_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_ok,
  output logic [5:0]  frame_length,
  output logic [7:0]  frame_type,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam int PW = (FW > 7) ? FW + 1 : 8;
  localparam logic [7:0]    LEN_CAP = 8'(BUFFER_DEPTH - 2);
  localparam logic [FW-1:0] DEPTH_F = FW'(BUFFER_DEPTH);

  typedef enum logic [1:0] {PH_HUNT, PH_LENGTH, PH_BODY} phase_t;
  typedef enum logic [2:0] {
    S_IDLE, S_CRC, S_SCAN_RD, S_SCAN_SYNC, S_SCAN_LEN, S_MOVE, S_DONE
  } state_t;

  state_t        state;
  phase_t        phase;
  logic [FW-1:0] fill;
  logic [5:0]    exp_len;
  logic [FW-1:0] iss_ptr;
  logic [FW-1:0] scan_ptr;
  logic          rvld;
  logic [FW-1:0] rtag;
  logic          res_ok;
  logic [5:0]    res_len;
  logic [7:0]    res_type;
  logic          res_ok_q;
  logic [7:0]    type_reg;
  logic [7:0]    sync_value;
  logic [5:0]    min_length;
  logic [5:0]    max_length;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  crc_ctrl_t     crc_ctrl;
  logic [7:0]    crc;

  logic          accept;
  logic          cfg_write;
  logic          lok_in;
  logic          lok_rd;
  logic          fill_room;
  logic [FW-1:0] fill_inc;
  logic          body_done;
  logic [PW-1:0] exp_ext;
  logic          iss_crc;
  logic          iss_move;
  logic [FW-1:0] rest;
  logic          rest_fits;
  logic          scan_last;
  logic [FW-1:0] move_src;

  // accepted length range test
  function automatic logic len_ok(input logic [7:0] len, input logic [5:0] lo_cfg,
                                  input logic [5:0] hi_cfg);
    logic [7:0] lo;
    lo = ({2'b00, lo_cfg} < LEN_FLOOR) ? LEN_FLOOR : {2'b00, lo_cfg};
    return (len >= lo) && (len <= {2'b00, hi_cfg}) && (len <= LEN_CAP);
  endfunction

  crsf_store #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  crsf_crc8 u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .data (rdata),
    .crc  (crc)
  );

  // handshake and decode
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  assign lok_in    = len_ok(rx_byte, min_length, max_length);
  assign lok_rd    = len_ok(rdata, min_length, max_length);
  assign fill_room = (fill < DEPTH_F);
  assign fill_inc  = fill_room ? fill + FW'(1) : fill;
  assign exp_ext   = PW'(exp_len);
  assign body_done = (PW'(fill_inc) >= exp_ext + PW'(2));
  assign iss_crc   = (PW'(iss_ptr) <= exp_ext + PW'(1));
  assign iss_move  = (iss_ptr < fill);
  assign rest      = fill - scan_ptr;
  assign rest_fits = (PW'(rest) < PW'(rdata) + PW'(2));
  assign scan_last = (scan_ptr == fill - FW'(1));
  assign move_src  = scan_ptr + iss_ptr;

  assign frame_ok  = res_ok_q;

  // register read
  always_comb begin
    case (paddr[3:2])
      REG_SYNC: prdata = {24'd0, sync_value};
      REG_MIN:  prdata = {26'd0, min_length};
      REG_MAX:  prdata = {26'd0, max_length};
      default:  prdata = '0;
    endcase
  end

  // buffer ports and CRC control
  always_comb begin
    we       = 1'b0;
    waddr    = '0;
    wdata    = rx_byte;
    re       = 1'b0;
    raddr    = '0;
    crc_ctrl = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (phase)
            PH_HUNT: begin
              if (rx_byte == sync_value) begin
                we    = 1'b1;
                wdata = sync_value;
              end
            end
            PH_LENGTH: begin
              if (lok_in) begin
                we    = 1'b1;
                waddr = AW'(1);
              end else if (rx_byte == sync_value) begin
                we    = 1'b1;
                wdata = sync_value;
              end
            end
            PH_BODY: begin
              we             = fill_room;
              waddr          = fill[AW-1:0];
              crc_ctrl.clear = body_done;
            end
            default: ;
          endcase
        end
      end
      S_CRC: begin
        re            = iss_crc;
        raddr         = iss_ptr[AW-1:0];
        crc_ctrl.step = rvld && (PW'(rtag) <= exp_ext);
      end
      S_SCAN_RD: begin
        re    = (scan_ptr < fill);
        raddr = scan_ptr[AW-1:0];
      end
      S_SCAN_SYNC: begin
        if (rdata == sync_value) begin
          if (scan_last) begin
            we    = 1'b1;
            wdata = sync_value;
          end else begin
            re    = 1'b1;
            raddr = scan_ptr[AW-1:0] + AW'(1);
          end
        end
      end
      S_MOVE: begin
        re    = iss_move;
        raddr = move_src[AW-1:0];
        we    = rvld;
        waddr = rtag[AW-1:0];
        wdata = rdata;
      end
      default: ;
    endcase
  end

  // sequencer, parser state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_HUNT;
      fill       <= '0;
      exp_len    <= '0;
      iss_ptr    <= '0;
      scan_ptr   <= '0;
      rvld       <= 1'b0;
      out_valid  <= 1'b0;
      sync_value <= SYNC_RESET;
      min_length <= MIN_RESET;
      max_length <= MAX_RESET;
    end else begin
      // configuration write
      if (cfg_write) begin
        case (paddr[3:2])
          REG_SYNC: sync_value <= pwdata[7:0];
          REG_MIN:  min_length <= pwdata[5:0];
          REG_MAX:  max_length <= pwdata[5:0];
          default: ;
        endcase
      end
      // drop a taken result
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_ok   <= 1'b0;
            res_len  <= '0;
            res_type <= '0;
            state    <= S_DONE;
            case (phase)
              PH_HUNT: begin
                if (rx_byte == sync_value) begin
                  fill    <= FW'(1);
                  exp_len <= '0;
                  phase   <= PH_LENGTH;
                end
              end
              PH_LENGTH: begin
                if (lok_in) begin
                  exp_len <= rx_byte[5:0];
                  fill    <= FW'(2);
                  phase   <= PH_BODY;
                end else if (rx_byte == sync_value) begin
                  fill    <= FW'(1);
                  exp_len <= '0;
                end else begin
                  fill  <= '0;
                  phase <= PH_HUNT;
                end
              end
              PH_BODY: begin
                fill <= fill_inc;
                if (body_done) begin
                  iss_ptr <= FW'(2);
                  rvld    <= 1'b0;
                  state   <= S_CRC;
                end
              end
              default: begin
                fill  <= '0;
                phase <= PH_HUNT;
              end
            endcase
          end
        end
        S_CRC: begin
          // stream type, payload and CRC byte through the read port
          rvld <= iss_crc;
          rtag <= iss_ptr;
          if (iss_crc) begin
            iss_ptr <= iss_ptr + FW'(1);
          end
          if (rvld && rtag == FW'(2)) begin
            type_reg <= rdata;
          end
          if (rvld && PW'(rtag) == exp_ext + PW'(1)) begin
            rvld <= 1'b0;
            if (crc == rdata) begin
              res_ok   <= 1'b1;
              res_len  <= exp_len;
              res_type <= type_reg;
              fill     <= '0;
              phase    <= PH_HUNT;
              state    <= S_DONE;
            end else begin
              scan_ptr <= FW'(1);
              state    <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          if (scan_ptr < fill) begin
            state <= S_SCAN_SYNC;
          end else begin
            fill  <= '0;
            phase <= PH_HUNT;
            state <= S_DONE;
          end
        end
        S_SCAN_SYNC: begin
          if (rdata != sync_value) begin
            scan_ptr <= scan_ptr + FW'(1);
            state    <= S_SCAN_RD;
          end else if (scan_last) begin
            fill    <= FW'(1);
            exp_len <= '0;
            phase   <= PH_LENGTH;
            state   <= S_DONE;
          end else begin
            state <= S_SCAN_LEN;
          end
        end
        S_SCAN_LEN: begin
          if (lok_rd && rest_fits) begin
            exp_len <= rdata[5:0];
            fill    <= rest;
            iss_ptr <= '0;
            rvld    <= 1'b0;
            state   <= S_MOVE;
          end else begin
            scan_ptr <= scan_ptr + FW'(1);
            state    <= S_SCAN_RD;
          end
        end
        S_MOVE: begin
          // copy the tail to the front, one byte a cycle
          rvld <= iss_move;
          rtag <= iss_ptr;
          if (iss_move) begin
            iss_ptr <= iss_ptr + FW'(1);
          end
          if (rvld && rtag == fill - FW'(1)) begin
            rvld  <= 1'b0;
            phase <= PH_BODY;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hand the result to the output register
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            res_ok_q     <= res_ok;
            frame_length <= res_len;
            frame_type   <= res_type;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // an idle body phase never holds a complete frame
  a_body_open: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && phase == PH_BODY) |-> (PW'(fill) < exp_ext + PW'(2)))
    else $error("idle body phase holds a complete frame");

  // hunting keeps an empty buffer
  a_hunt_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && phase == PH_HUNT) |-> (fill == '0))
    else $error("hunt phase with nonzero fill");

  // fill count stays within the buffer
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_F)
    else $error("fill count beyond buffer depth");

  // a resumed tail holds at least sync and length
  a_move_tail: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |-> (fill >= FW'(2)))
    else $error("tail copy shorter than two bytes");

  // an accepted byte takes in_ready low right after the accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("ready right after accept");

endmodule

// File: bench/tb_crsf_frame_parser_crc8_core.sv
// ----------------------------------------------------------------------------
// tb_crsf_frame_parser_crc8_core
// Self-checking bench for the CRSF frame parser. A byte-level parser model
// predicts one report per accepted byte (frame_ok, length, type), covering the
// sync hunt, the length window, the CRC-8 check and buffer resync after a bad
// CRC. Traffic is mostly well-formed frames with random content, mixed with
// nested frames, truncated frames and noise. It runs under several register
// settings and with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_crsf_frame_parser_crc8_core;
  timeunit 1ns;
  timeprecision 1ps;

  import crsf_pkg::*;

  localparam int         BUF_DEPTH       = 64;
  localparam logic [7:0] CRC8_POLY       = 8'hD5;
  localparam logic [1:0] REG_UNUSED      = 2'd3;
  localparam int         CYCLE_LIMIT     = 3_000_000;
  localparam int         HOLD_CYCLES     = 300;
  localparam int         KEEP_ALL        = 1000;

  typedef enum logic [1:0] {SEEK_SYNC, SEEK_LENGTH, COLLECT_BODY} parse_phase_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] length;
    logic [7:0] type_byte;
  } frame_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        frame_ok;
  logic [5:0]  frame_length;
  logic [7:0]  frame_type;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // register mirror
  logic [7:0] cfg_sync    = SYNC_RESET;
  logic [5:0] cfg_min_len = MIN_RESET;
  logic [5:0] cfg_max_len = MAX_RESET;

  // parser model state
  parse_phase_t parse_phase = SEEK_SYNC;
  logic [7:0]   frame_copy [BUF_DEPTH];
  int           bytes_held  = 0;
  int           body_length = 0;

  logic [7:0]    rx_backlog [$];
  logic [7:0]    frame_words [$];
  frame_report_t expected_reports [$];
  frame_report_t want_report;

  int words_posted  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  crsf_frame_parser_crc8_core #(
    .BUFFER_DEPTH(BUF_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_ok    (frame_ok),
    .frame_length(frame_length),
    .frame_type  (frame_type),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // parser model
  // --------------------------------------------------------------------------

  // one byte through CRC-8, MSB first
  function automatic logic [7:0] crc8_d5_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC8_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic bit length_accepted(input int len);
    int lo;
    lo = (cfg_min_len < 2) ? 2 : int'(cfg_min_len);
    return len >= lo && len <= int'(cfg_max_len) && len + 2 <= BUF_DEPTH;
  endfunction

  task automatic restart_frame();
    frame_copy[0] = cfg_sync;
    bytes_held    = 1;
    body_length   = 0;
    parse_phase   = SEEK_LENGTH;
  endtask

  // after a bad CRC, look for a later sync byte that can start a frame
  task automatic resync_from_buffer();
    int rest;
    int len;
    for (int i = 1; i < bytes_held; i++) begin
      if (frame_copy[i] == cfg_sync) begin
        rest = bytes_held - i;
        if (rest == 1) begin
          restart_frame();
          return;
        end
        len = frame_copy[i + 1];
        // skip a candidate that would already be complete
        if (length_accepted(len) && rest < len + 2) begin
          for (int k = 0; k < rest; k++) frame_copy[k] = frame_copy[i + k];
          bytes_held  = rest;
          body_length = len;
          parse_phase = COLLECT_BODY;
          return;
        end
      end
    end
    bytes_held  = 0;
    parse_phase = SEEK_SYNC;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    frame_report_t rep;
    logic [7:0]    crc;
    int            last;
    rep = '0;
    case (parse_phase)
      SEEK_SYNC: begin
        if (b == cfg_sync) restart_frame();
      end
      SEEK_LENGTH: begin
        // the length window is tested before a repeated sync
        if (length_accepted(b)) begin
          body_length   = b;
          frame_copy[1] = b;
          bytes_held    = 2;
          parse_phase   = COLLECT_BODY;
        end else if (b == cfg_sync) begin
          restart_frame();
        end else begin
          bytes_held  = 0;
          parse_phase = SEEK_SYNC;
        end
      end
      default: begin
        if (bytes_held < BUF_DEPTH) begin
          frame_copy[bytes_held] = b;
          bytes_held++;
        end
        if (bytes_held >= body_length + 2) begin
          last = body_length + 1;
          crc  = 8'h00;
          for (int i = 2; i < last; i++) crc = crc8_d5_step(crc, frame_copy[i]);
          if (crc == frame_copy[last]) begin
            rep.ok        = 1'b1;
            rep.length    = 6'(body_length);
            rep.type_byte = frame_copy[2];
            bytes_held    = 0;
            parse_phase   = SEEK_SYNC;
          end else begin
            resync_from_buffer();
          end
        end
      end
    endcase
    expected_reports.push_back(rep);
  endtask

  // --------------------------------------------------------------------------
  // traffic generation
  // --------------------------------------------------------------------------

  task automatic post_word(input logic [7:0] b);
    rx_backlog.push_back(b);
    words_posted++;
  endtask

  // accepted length of at least floor_len, mostly short; 0 when none exists
  function automatic int pick_length(input int floor_len);
    int lo;
    int hi;
    int r;
    lo = (cfg_min_len < 2) ? 2 : int'(cfg_min_len);
    if (floor_len > lo) lo = floor_len;
    hi = (int'(cfg_max_len) > BUF_DEPTH - 2) ? BUF_DEPTH - 2 : int'(cfg_max_len);
    if (lo > hi) return 0;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(lo, (hi < lo + 8) ? hi : lo + 8);
    if (r < 95) return $urandom_range(lo, hi);
    return hi;
  endfunction

  // build sync, length, type, payload and CRC; post up to keep words of it
  task automatic add_frame(input int len, input bit corrupt, input bit lead_sync,
                           input int keep);
    logic [7:0] crc;
    logic [7:0] b;
    int         sent;
    crc  = 8'h00;
    sent = 0;
    frame_words.delete();
    frame_words.push_back(cfg_sync);
    frame_words.push_back(8'(len));
    for (int k = 0; k + 1 < len; k++) begin
      if (k == 0 && $urandom_range(0, 9) == 0) begin
        b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      crc = crc8_d5_step(crc, b);
      frame_words.push_back(b);
    end
    if (len > 0) frame_words.push_back(corrupt ? crc ^ 8'($urandom_range(1, 255)) : crc);
    foreach (frame_words[k]) begin
      if ((k > 0 || lead_sync) && sent < keep) begin
        post_word(frame_words[k]);
        sent++;
      end
    end
  endtask

  task automatic queue_random_traffic(input int count);
    int target;
    int kind;
    int len;
    int inner_len;
    int outer_len;
    int rest;
    int pad;
    target = words_posted + count;
    while (words_posted < target) begin
      kind = $urandom_range(0, 99);
      len  = pick_length(2);
      if (len == 0) begin
        // no length passes the window: frames of any length are noise
        add_frame($urandom_range(0, 63), $urandom_range(0, 1), 1'b1, KEEP_ALL);
      end else if (kind < 45) begin
        add_frame(len, 1'b0, 1'b1, KEEP_ALL);
      end else if (kind < 55) begin
        add_frame(len, 1'b1, 1'b1, KEEP_ALL);
      end else if (kind < 67) begin
        // bad frame whose tail holds the head of a frame still arriving
        rest      = $urandom_range(2, len + 1);
        outer_len = pick_length(rest);
        if (outer_len == 0) begin
          add_frame(len, 1'b0, 1'b1, KEEP_ALL);
        end else begin
          post_word(cfg_sync);
          post_word(8'(outer_len));
          repeat (outer_len - rest) post_word(8'($urandom_range(0, 255)));
          add_frame(len, 1'b0, 1'b1, KEEP_ALL);
        end
      end else if (kind < 73) begin
        // whole inner frame inside a bad frame: the candidate is skipped
        inner_len = pick_length(2);
        outer_len = pick_length(inner_len + 2 + $urandom_range(0, 3));
        if (outer_len == 0) begin
          add_frame(len, 1'b0, 1'b1, KEEP_ALL);
        end else begin
          pad = $urandom_range(0, outer_len - inner_len - 2);
          post_word(cfg_sync);
          post_word(8'(outer_len));
          repeat (pad) post_word(8'($urandom_range(0, 255)));
          add_frame(inner_len, 1'b0, 1'b1, KEEP_ALL);
          repeat (outer_len - inner_len - 2 - pad) post_word(8'($urandom_range(0, 255)));
        end
      end else if (kind < 80) begin
        // sync as the last byte of a bad frame, then a frame without its sync
        outer_len = pick_length(3);
        if (outer_len == 0) begin
          add_frame(len, 1'b0, 1'b1, KEEP_ALL);
        end else begin
          post_word(cfg_sync);
          post_word(8'(outer_len));
          repeat (outer_len - 1) post_word(8'($urandom_range(0, 255)));
          post_word(cfg_sync);
          add_frame(len, 1'b0, 1'b0, KEEP_ALL);
        end
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 6)) post_word(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0) begin
          post_word(cfg_sync);
          case ($urandom_range(0, 3))
            0:       post_word(8'd0);
            1:       post_word(8'd1);
            2:       post_word(8'd63);
            default: post_word((cfg_max_len == 6'd63) ? 8'd63 : 8'(cfg_max_len) + 8'd1);
          endcase
        end
      end else if (kind < 95) begin
        // repeated sync restarts the frame
        post_word(cfg_sync);
        add_frame(len, 1'b0, 1'b1, KEEP_ALL);
      end else begin
        // truncated frame; what follows is taken as its body
        add_frame(len, 1'b0, 1'b1, $urandom_range(2, len + 1));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // configuration and flow control
  // --------------------------------------------------------------------------

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      REG_SYNC: cfg_sync    = value[7:0];
      REG_MIN:  cfg_min_len = value[5:0];
      REG_MAX:  cfg_max_len = value[5:0];
      default:  ;
    endcase
  endtask

  task automatic apply_setting(input logic [7:0] sync, input logic [5:0] min_len,
                               input logic [5:0] max_len);
    write_register(REG_SYNC, {24'($urandom), sync});
    write_register(REG_MIN, {26'($urandom), min_len});
    write_register(REG_MAX, {26'($urandom), max_len});
  endtask

  // wait until the backlog is sent and every expected report has come back
  task automatic wait_for_drain();
    while (rx_backlog.size() != 0 || in_valid || expected_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // byte driver: predict on accept, offer the next word from the backlog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parse_rx_byte(rx_byte);
      if (!in_valid || in_ready) begin
        if (rx_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: compare against the oldest report, drive out_ready
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          error_count++;
          $display("%0t: expected no result, got frame_ok %0d length %0d type %0d",
                   $time, frame_ok, frame_length, frame_type);
        end else begin
          want_report = expected_reports.pop_front();
          check_field("frame_ok", 8'(want_report.ok), 8'(frame_ok));
          check_field("frame_length", 8'(want_report.length), 8'(frame_length));
          check_field("frame_type", want_report.type_byte, frame_type);
        end
      end
      // long hold-off on request, else random idling
      if (holds_served != hold_requests) begin
        holds_served = holds_served + 1;
        hold_left    = HOLD_CYCLES;
        out_ready   <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left  = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // timeout
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // sender idles less than the receiver
    send_idle_pct = 38;
    recv_idle_pct = 59;

    // directed: noise, rejected lengths, repeated sync, minimal frame,
    // sync as the last byte of a bad frame
    post_word(8'h00);
    post_word(8'hFF);
    post_word(cfg_sync);
    post_word(8'd0);
    post_word(cfg_sync);
    post_word(8'd1);
    post_word(cfg_sync);
    post_word(8'd63);
    post_word(cfg_sync);
    add_frame(2, 1'b0, 1'b1, KEEP_ALL);
    post_word(cfg_sync);
    post_word(8'd3);
    post_word(8'h00);
    post_word(8'h00);
    post_word(cfg_sync);
    add_frame(2, 1'b0, 1'b0, KEEP_ALL);
    queue_random_traffic(230);
    wait_for_drain();

    // zero sync, minimum below the floor, maximum beyond the buffer
    apply_setting(8'h00, 6'd0, 6'd63);
    queue_random_traffic(250);
    wait_for_drain();

    // receiver idles less than the sender
    send_idle_pct = 59;
    recv_idle_pct = 38;

    // only the longest frame passes
    apply_setting(8'hFF, 6'd62, 6'd62);
    queue_random_traffic(200);
    wait_for_drain();

    // empty length window; an unmapped register write must change nothing
    write_register(REG_UNUSED, $urandom);
    apply_setting(8'h5A, 6'd40, 6'd10);
    queue_random_traffic(120);
    wait_for_drain();

    // no idling, with long receiver hold-offs to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;

    apply_setting(8'hC8, 6'd2, 6'd8);
    queue_random_traffic(250);
    hold_requests = hold_requests + 1;
    wait_for_drain();

    apply_setting(8'h81, 6'd3, 6'd20);
    hold_requests = hold_requests + 1;
    queue_random_traffic(200);
    wait_for_drain();

    apply_setting(SYNC_RESET, MIN_RESET, MAX_RESET);
    queue_random_traffic(200);
    wait_for_drain();

    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/crsf_pkg.sv
src/crsf_store.sv
src/crsf_crc8.sv
src/crsf_frame_parser_crc8_core.sv
bench/tb_crsf_frame_parser_crc8_core.sv
